>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the date-ordered queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

>>> rtl/core/dopq_pkg.sv
// Package: field widths, codes and entry type of the date-ordered queue
`default_nettype none

package dopq_pkg;

    localparam int DOPQ_CAPACITY = 16;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int TAG_W   = 16;
    localparam int FILL_W  = 5;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    // Sort key: year, then month, then day, as one unsigned number
    function automatic logic [KEY_W-1:0] entry_key(input t_entry e);
        entry_key = {e.year, e.month, e.day};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dopq_req_if.sv
// Request channel interface: operation and entry fields with valid/ready
`default_nettype none

interface dopq_req_if;
    import dopq_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [DAY_W-1:0]   arrival_day;
    logic [MONTH_W-1:0] arrival_month;
    logic [YEAR_W-1:0]  arrival_year;
    logic [TAG_W-1:0]   entry_tag;

    modport source (
        output valid, operation, arrival_day, arrival_month, arrival_year, entry_tag,
        input  ready
    );

    modport sink (
        input  valid, operation, arrival_day, arrival_month, arrival_year, entry_tag,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/dopq_rsp_if.sv
// Response channel interface: status, removed entry and fill count with valid/ready
`default_nettype none

interface dopq_rsp_if;
    import dopq_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic [TAG_W-1:0]   out_tag;
    logic [FILL_W-1:0]  fill_count;

    modport source (
        output valid, status, out_day, out_month, out_year, out_tag, fill_count,
        input  ready
    );

    modport sink (
        input  valid, status, out_day, out_month, out_year, out_tag, fill_count,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/date_ordered_priority_queue_top.sv
// Top level: date-ordered priority queue held in a circular memory with one write and one read port
//
//  channel   | dir | payload                                              | handshake
//  ----------+-----+------------------------------------------------------+------------
//  i_req     | in  | operation, arrival_day/month/year, entry_tag         | valid/ready
//  o_rsp     | out | status, out_day/month/year, out_tag, fill_count      | valid/ready
//
//  Full insert, empty remove or insert into an empty queue go straight from idle to finish.
//  Remove reads the head entry, then finishes. Any other insert walks from the tail, moving
//  every held entry with a later date one slot towards the tail through the one memory write
//  port, then writes the new entry and finishes. Finish waits until the output register is free.
//  One item is worked at a time; i_req.ready is high while no item is in work.
//  A finished result waits in its own register until o_rsp takes it.
//  Reset (synchronous, active low) empties the queue; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module date_ordered_priority_queue_top #(
    parameter int CAPACITY = dopq_pkg::DOPQ_CAPACITY
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dopq_req_if.sink    i_req,
    dopq_rsp_if.source  o_rsp
);
    import dopq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RMV  = 5'b00010,
        S_CMP  = 5'b00100,
        S_PUT  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // Logical slot to physical address, the head being logical slot 0
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] slot);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, slot};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        phys = sum[AW-1:0];
    endfunction

    t_entry mem [CAPACITY];
    t_entry r_rd_data;

    t_state  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_pos, n_pos;
    t_entry  r_new, n_new;
    t_status r_res_status, n_res_status;
    t_entry  r_res_entry, n_res_entry;

    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    t_entry        r_out_entry, n_out_entry;
    logic [FILL_W-1:0] r_out_fill, n_out_fill;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic [AW-1:0] rd_addr;

    logic          out_free;
    logic          new_earlier;
    t_entry        req_entry;
    logic [CW+FILL_W-1:0] count_wide;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign new_earlier = entry_key(r_new) < entry_key(r_rd_data);
    assign count_wide  = {{FILL_W{1'b0}}, r_count};

    assign req_entry.day   = i_req.arrival_day;
    assign req_entry.month = i_req.arrival_month;
    assign req_entry.year  = i_req.arrival_year;
    assign req_entry.tag   = i_req.entry_tag;

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_pos        = r_pos;
        n_new        = r_new;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_fill   = r_out_fill;
        wr_en        = 1'b0;
        wr_addr      = r_head;
        wr_data      = r_new;
        rd_addr      = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_new       = req_entry;
                    n_res_entry = '0;
                    n_state     = S_FIN;
                    if (i_req.operation == OP_REMOVE) begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            rd_addr = r_head;
                            n_state = S_RMV;
                        end
                    end else if (r_count >= CW'(CAPACITY)) begin
                        n_res_status = ST_FULL;
                    end else if (r_count == '0) begin
                        wr_en        = 1'b1;
                        wr_addr      = r_head;
                        wr_data      = req_entry;
                        n_count      = r_count + 1'b1;
                        n_res_status = ST_INSERTED;
                    end else begin
                        // Walk from the tail towards the head
                        n_pos   = r_count[AW-1:0];
                        rd_addr = phys(r_head, r_count[AW-1:0] - 1'b1);
                        n_state = S_CMP;
                    end
                end
            end
            S_RMV: begin
                n_res_status = ST_REMOVED;
                n_res_entry  = r_rd_data;
                n_head       = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
                n_count      = r_count - 1'b1;
                n_state      = S_FIN;
            end
            S_CMP: begin
                wr_en   = 1'b1;
                wr_addr = phys(r_head, r_pos);
                if (new_earlier) begin
                    // Move the later entry one slot towards the tail
                    wr_data = r_rd_data;
                    n_pos   = r_pos - 1'b1;
                    if (r_pos == AW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        rd_addr = phys(r_head, r_pos - AW'(2));
                    end
                end else begin
                    wr_data      = r_new;
                    n_count      = r_count + 1'b1;
                    n_res_status = ST_INSERTED;
                    n_state      = S_FIN;
                end
            end
            S_PUT: begin
                wr_en        = 1'b1;
                wr_addr      = r_head;
                wr_data      = r_new;
                n_count      = r_count + 1'b1;
                n_res_status = ST_INSERTED;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // Hold the result until the output register is free
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_entry  = r_res_entry;
                    n_out_fill   = count_wide[FILL_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Entry memory: one write and one registered read per cycle; the walk never uses read
    // data from the slot it writes in the same cycle, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_new        <= n_new;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_fill   <= n_out_fill;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.out_day    = r_out_entry.day;
    assign o_rsp.out_month  = r_out_entry.month;
    assign o_rsp.out_year   = r_out_entry.year;
    assign o_rsp.out_tag    = r_out_entry.tag;
    assign o_rsp.fill_count = r_out_fill;

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "entry count above capacity")
    `ASSERT_NEVER(a_walk_pos, i_clk, i_rst_n, r_state == S_CMP && r_pos == '0, "walk at head slot in compare")
    `ASSERT_CLK(a_out_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_FIN), "result raised outside finish")

endmodule

`default_nettype wire
